// ===== rtl/core/rmv_pkg.sv =====
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared types and constants for the running mean / variance / min-max block.
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned MeanW   = SampleW + 16;
  localparam int unsigned MagW    = MeanW + 1;
  localparam int unsigned SqW     = 64;
  localparam int unsigned VarW    = 63;
  localparam int unsigned AluW    = 66;
  localparam int unsigned StepW   = 6;
  localparam int unsigned OutDataW = 224;

  typedef enum logic [3:0] {
    StIdle,
    StDiff,
    StMag,
    StDiv,
    StMsub,
    StMul,
    StAcc,
    StMean,
    StVdiv,
    StSqrt,
    StDone
  } rmv_state_e;

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic [SampleW-1:0] mean;
    logic [VarW-1:0]    variance;
    logic [31:0]        std_dev;
    logic [SampleW-1:0] smallest;
    logic [SampleW-1:0] largest;
  } rmv_result_t;

endpackage

// ===== rtl/core/rmv_alu.sv =====
// ----------------------------------------------------------------------------
// rmv_alu
// Shared add/subtract unit. Carry out of a subtract is set when a >= b.
// ----------------------------------------------------------------------------
module rmv_alu (
  input  logic [rmv_pkg::AluW-1:0] a_i,
  input  logic [rmv_pkg::AluW-1:0] b_i,
  input  logic                     sub_i,
  output logic [rmv_pkg::AluW:0]   res_o
);
  import rmv_pkg::*;

  logic [AluW-1:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign res_o = {1'b0, a_i} + {1'b0, b_op} + {{AluW{1'b0}}, sub_i};

endmodule

// ===== rtl/core/rmv_core.sv =====
// ----------------------------------------------------------------------------
// rmv_core
// Sequencer and state: Welford update, variance divide and square root, all
// through one shared add/subtract unit.
// ----------------------------------------------------------------------------
module rmv_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_mode_i,
  input  logic [rmv_pkg::SampleW-1:0] in_sample_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output rmv_pkg::rmv_result_t       res_o
);
  import rmv_pkg::*;

  rmv_state_e state_q, state_d;

  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [MeanW-1:0]   mean_q, mean_d;
  logic [SqW-1:0]     m2_q, m2_d;
  logic [SampleW-1:0] min_q, min_d, max_q, max_d;
  logic [SampleW-1:0] x_q, x_d;
  logic               neg_q, neg_d;
  logic [MagW-1:0]    mag_q, mag_d;
  logic [SqW-1:0]     wa_q, wa_d;
  logic [33:0]        rem_q, rem_d;
  logic [CountW-1:0]  dvs_q, dvs_d;
  logic [MagW:0]      ph_q, ph_d;
  logic [MagW-1:0]    pl_q, pl_d;
  logic [VarW-1:0]    var_q, var_d;
  logic [31:0]        root_q, root_d;
  logic [StepW-1:0]   step_q, step_d;

  logic [AluW-1:0] alu_a, alu_b;
  logic            alu_sub;
  logic [AluW:0]   alu_res;

  logic [MeanW-1:0] xs;
  logic             div_bit, ge;
  logic [MagW:0]    mul_t;
  logic [SqW-1:0]   inc, vquo;

  rmv_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .res_o(alu_res)
  );

  assign xs      = {x_q, 16'b0};
  assign ge      = alu_res[AluW];
  assign div_bit = (state_q == StVdiv) ? wa_q[SqW-1] : wa_q[MagW-1];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mean_d  = mean_q;
    m2_d    = m2_q;
    min_d   = min_q;
    max_d   = max_q;
    x_d     = x_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    wa_d    = wa_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    ph_d    = ph_q;
    pl_d    = pl_q;
    var_d   = var_q;
    root_d  = root_q;
    step_d  = step_q;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    mul_t   = '0;
    inc     = '0;
    vquo    = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i || cnt_q == '0) begin
            cnt_d   = {{(CountW-1){1'b0}}, 1'b1};
            mean_d  = {in_sample_i, 16'b0};
            m2_d    = '0;
            min_d   = in_sample_i;
            max_d   = in_sample_i;
            var_d   = '0;
            root_d  = '0;
            state_d = StDone;
          end else begin
            x_d   = in_sample_i;
            cnt_d = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
            dvs_d = cnt_d;
            if ($signed(in_sample_i) < $signed(min_q)) min_d = in_sample_i;
            if ($signed(max_q) < $signed(in_sample_i)) max_d = in_sample_i;
            state_d = StDiff;
          end
        end
      end
      StDiff: begin
        alu_a   = {{(AluW-MeanW){xs[MeanW-1]}}, xs};
        alu_b   = {{(AluW-MeanW){mean_q[MeanW-1]}}, mean_q};
        alu_sub = 1'b1;
        neg_d   = alu_res[AluW-1];
        state_d = StMag;
      end
      StMag: begin
        alu_a   = neg_q ? {{(AluW-MeanW){mean_q[MeanW-1]}}, mean_q}
                        : {{(AluW-MeanW){xs[MeanW-1]}}, xs};
        alu_b   = neg_q ? {{(AluW-MeanW){xs[MeanW-1]}}, xs}
                        : {{(AluW-MeanW){mean_q[MeanW-1]}}, mean_q};
        alu_sub = 1'b1;
        mag_d   = alu_res[MagW-1:0];
        wa_d    = {{(SqW-MagW){1'b0}}, alu_res[MagW-1:0]};
        rem_d   = '0;
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv, StVdiv: begin
        // restoring divide, one quotient bit per cycle
        alu_a   = {{(AluW-33){1'b0}}, rem_q[31:0], div_bit};
        alu_b   = {{(AluW-CountW){1'b0}}, dvs_q};
        alu_sub = 1'b1;
        rem_d   = {2'b0, ge ? alu_res[31:0] : alu_a[31:0]};
        wa_d    = {wa_q[SqW-2:0], ge};
        step_d  = step_q + 1'b1;
        if (state_q == StDiv && step_q == StepW'(MagW-1)) begin
          state_d = StMsub;
        end else if (state_q == StVdiv && step_q == StepW'(SqW-1)) begin
          vquo    = {wa_q[SqW-2:0], ge};
          var_d   = vquo[SqW-1] ? {VarW{1'b1}} : vquo[VarW-1:0];
          wa_d    = {1'b0, var_d};
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = StSqrt;
        end
      end
      StMsub: begin
        alu_a   = {{(AluW-MagW){1'b0}}, mag_q};
        alu_b   = {{(AluW-MagW){1'b0}}, wa_q[MagW-1:0]};
        alu_sub = 1'b1;
        pl_d    = alu_res[MagW-1:0];
        ph_d    = '0;
        step_d  = '0;
        state_d = StMul;
      end
      StMul: begin
        // shift-add multiply, one multiplier bit per cycle
        alu_a  = {{(AluW-MagW-1){1'b0}}, ph_q};
        alu_b  = {{(AluW-MagW){1'b0}}, mag_q};
        mul_t  = pl_q[0] ? alu_res[MagW:0] : ph_q;
        ph_d   = {1'b0, mul_t[MagW:1]};
        pl_d   = {mul_t[0], pl_q[MagW-1:1]};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(MagW-1)) state_d = StAcc;
      end
      StAcc: begin
        // product >> 32, saturated to 64 bits
        inc     = (|ph_q[MagW-1:MagW-2]) ? {SqW{1'b1}}
                                         : {ph_q[MagW-3:0], pl_q[MagW-1:32]};
        alu_a   = {{(AluW-SqW){1'b0}}, m2_q};
        alu_b   = {{(AluW-SqW){1'b0}}, inc};
        m2_d    = alu_res[SqW] ? {SqW{1'b1}} : alu_res[SqW-1:0];
        state_d = StMean;
      end
      StMean: begin
        alu_a   = {{(AluW-MeanW){mean_q[MeanW-1]}}, mean_q};
        alu_b   = {{(AluW-MagW){1'b0}}, wa_q[MagW-1:0]};
        alu_sub = neg_q;
        mean_d  = alu_res[MeanW-1:0];
        wa_d    = m2_q;
        rem_d   = '0;
        dvs_d   = cnt_q - 1'b1;
        step_d  = '0;
        state_d = StVdiv;
      end
      StSqrt: begin
        // digit-by-digit root, two radicand bits per cycle
        alu_a   = {{(AluW-35){1'b0}}, rem_q[32:0], wa_q[SqW-1:SqW-2]};
        alu_b   = {{(AluW-34){1'b0}}, root_q, 2'b01};
        alu_sub = 1'b1;
        rem_d   = ge ? alu_res[33:0] : alu_a[33:0];
        root_d  = {root_q[30:0], ge};
        wa_d    = {wa_q[SqW-3:0], 2'b00};
        step_d  = step_q + 1'b1;
        if (step_q == StepW'(31)) state_d = StDone;
      end
      StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign res_o.count    = cnt_q;
  assign res_o.mean     = mean_q[MeanW-1:16];
  assign res_o.variance = var_q;
  assign res_o.std_dev  = root_q;
  assign res_o.smallest = min_q;
  assign res_o.largest  = max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      mean_q  <= '0;
      m2_q    <= '0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mean_q  <= mean_d;
      m2_q    <= m2_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    wa_q   <= wa_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    ph_q   <= ph_d;
    pl_q   <= pl_d;
    var_q  <= var_d;
    root_q <= root_d;
    step_q <= step_d;
  end

endmodule

// ===== rtl/core/running_mean_variance_minmax.sv =====
// ----------------------------------------------------------------------------
// running_mean_variance_minmax
// Welford running count, mean, variance, std deviation, min and max.
//
//   channel  dir  tdata fields (low bit up)                         tuser
//   s_axis   in   sample[31:0]                                      mode
//   m_axis   out  count, mean, variance(63), std_dev, min, max, pad -
//
// An add request runs 49 divide steps for the mean correction, 49 shift-add
// multiply steps, 64 variance divide steps and 32 square root steps, all on
// one shared add/subtract unit.
// A start request (or an add on an empty series) goes straight to the result.
// Reset zeroes count, mean, min and max. A new request is taken only when
// the sequencer is idle; a finished result waits in the output register.
// ----------------------------------------------------------------------------
module running_mean_variance_minmax (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // sample[31:0]
  input  logic [0:0]  s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // sample_count[31:0], running_mean[63:32], sample_variance[126:64],
  // std_deviation[158:127], smallest_sample[190:159], largest_sample[222:191]
  output logic [rmv_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rmv_pkg::*;

  logic        res_valid, res_ready;
  rmv_result_t res;
  logic        ovalid_q, ovalid_d;
  logic [OutDataW-1:0] odata_q;

  rmv_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_mode_i  (s_axis_tuser_i[0]),
    .in_sample_i(s_axis_tdata_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !ovalid_q || m_axis_tready_i;
  assign ovalid_d  = res_valid || (ovalid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      odata_q <= {1'b0, res.largest, res.smallest, res.std_dev, res.variance,
                  res.mean, res.count};
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule
